[hw/rtl/uveu_pkg.sv]
package uveu_pkg;

  // Default number of fraction bits of a spin component
  localparam int SpinFracBitsDef = 30;

  // Word index of the step size register on the configuration port
  localparam logic CfgStepSize = 1'b0;

  // Number of spin components handled side by side
  localparam int NumLanes = 3;

endpackage

[hw/rtl/unit_vector_euler_update_top.sv]
// Forward Euler advance of a unit spin vector with renormalization.
// Usage: program the step size through the APB port (word 0) while the
// block is idle. Raise start with the spin and rate components of one cell;
// the item is taken at that edge, since busy stays low and the block takes
// one item in every cycle. Each result is shown on new_x_o/new_y_o/new_z_o
// while valid_o is high for one cycle.
// Results come out in input order, one per item.
// The pipeline is made of the two pipelined dividers and the pipelined square
// root, each one register stage per result bit (SPIN_FRAC_BITS + 2 each),
// plus eleven stages for the multiplies, sums and rounding around them.
// The receiver cannot stall: a result is shown for exactly one cycle.
// Reset clears the pipeline valid bits and the step size; items in flight
// are dropped. A zero sum vector yields (1, 0, 0).
module unit_vector_euler_update_top
  import uveu_pkg::*;
#(
  parameter int SPIN_FRAC_BITS = SpinFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] spin_x_i,
  input  logic signed [31:0] spin_y_i,
  input  logic signed [31:0] spin_z_i,
  input  logic signed [31:0] rate_x_i,
  input  logic signed [31:0] rate_y_i,
  input  logic signed [31:0] rate_z_i,
  output logic               valid_o,
  output logic signed [31:0] new_x_o,
  output logic signed [31:0] new_y_o,
  output logic signed [31:0] new_z_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int F     = SPIN_FRAC_BITS;
  localparam int MW    = F + 2;          // saturated spin, signed
  localparam int TMW   = F + 2;          // step vector magnitude
  localparam int SQW   = 2 * TMW;
  localparam int SUMW  = SQW + 2;
  localparam int ADW   = F + 3;          // adj up to 6.0
  localparam int DDW   = F + 3;          // 1 + adj
  localparam int QMW   = F + 3;
  localparam int EW    = ADW + F + 2;
  localparam int NMW   = F + 4;          // |t - q|
  localparam int N1W   = NMW + F + 1;
  localparam int Q1W   = F + 2;
  localparam int VMW   = F + 2;          // |m + t'|
  localparam int SW    = 2 * VMW;
  localparam int RW    = SW / 2;
  localparam int N2W   = 2 * F + 2;
  localparam int Q2W   = F + 2;
  localparam int Latency = 3 * F + 17;

  localparam logic signed [31:0] SpinMax = 32'sd1 <<< F;
  localparam logic [57:0]        TsatW   = 58'(1) << (F + 1);

  logic accept;
  logic step_wr;
  logic [31:0] step_size_q;

  // Configuration port
  assign pready  = 1'b1;
  assign step_wr = psel && penable && pwrite && (paddr[2] == CfgStepSize);
  assign prdata  = (paddr[2] == CfgStepSize) ? step_size_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q <= '0;
    end else if (step_wr) begin
      step_size_q <= pwdata;
    end
  end

  assign busy   = 1'b0;
  assign accept = start && !busy;

  logic signed [31:0] spin_in [NumLanes];
  logic signed [31:0] rate_in [NumLanes];
  assign spin_in[0] = spin_x_i;
  assign spin_in[1] = spin_y_i;
  assign spin_in[2] = spin_z_i;
  assign rate_in[0] = rate_x_i;
  assign rate_in[1] = rate_y_i;
  assign rate_in[2] = rate_z_i;

  // Stage A: saturate spin, multiply rate magnitude by step size
  logic signed [MW-1:0] a_m_d [NumLanes], a_m_q [NumLanes];
  logic [31:0]          a_rmag [NumLanes];
  logic [63:0]          a_p_d [NumLanes], a_p_q [NumLanes];
  logic                 a_neg_q [NumLanes];
  logic                 a_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (spin_in[i] > SpinMax) begin
        a_m_d[i] = MW'(SpinMax);
      end else if (spin_in[i] < -SpinMax) begin
        a_m_d[i] = MW'(-SpinMax);
      end else begin
        a_m_d[i] = MW'(spin_in[i]);
      end
      a_rmag[i] = rate_in[i][31] ? 32'(-rate_in[i]) : rate_in[i];
      a_p_d[i]  = 64'(a_rmag[i]) * 64'(step_size_q);
    end
  end

  // Stage B: round the step vector to Q.F and saturate at 2
  logic [57:0]          b_rnd [NumLanes];
  logic [57:0]          b_sh  [NumLanes];
  logic [TMW-1:0]       b_tm_d [NumLanes], b_tm_q [NumLanes];
  logic signed [MW-1:0] b_m_q [NumLanes];
  logic                 b_neg_q [NumLanes];
  logic                 b_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      b_rnd[i] = 58'(a_p_q[i][56:0]) + (58'(1) << (55 - F));
      b_sh[i]  = b_rnd[i] >> (56 - F);
      if (|a_p_q[i][63:57] || (b_sh[i] > TsatW)) begin
        b_tm_d[i] = TMW'(TsatW);
      end else begin
        b_tm_d[i] = TMW'(b_sh[i]);
      end
    end
  end

  // Stage C: square each component
  logic [SQW-1:0]       c_sq_q [NumLanes];
  logic [TMW-1:0]       c_tm_q [NumLanes];
  logic signed [MW-1:0] c_m_q [NumLanes];
  logic                 c_neg_q [NumLanes];
  logic                 c_vld_q;

  // Stage D: adj = |t|^2 / 2 and the divisor 1 + adj
  logic [SUMW-1:0]      d_sum;
  logic [SUMW-1:0]      d_rnd;
  logic [ADW-1:0]       d_adj_q;
  logic [DDW-1:0]       d_d_q;
  logic [TMW-1:0]       d_tm_q [NumLanes];
  logic signed [MW-1:0] d_m_q [NumLanes];
  logic                 d_neg_q [NumLanes];
  logic                 d_vld_q;

  assign d_sum = SUMW'(c_sq_q[0]) + SUMW'(c_sq_q[1]) + SUMW'(c_sq_q[2]);
  assign d_rnd = d_sum + (SUMW'(1) << F);

  // Stage E: q = adj * |m|, rounded
  logic [F:0]           e_mm [NumLanes];
  logic [EW-1:0]        e_prod [NumLanes];
  logic [EW-1:0]        e_rnd [NumLanes];
  logic [QMW-1:0]       e_qm_q [NumLanes];
  logic [DDW-1:0]       e_d_q;
  logic [TMW-1:0]       e_tm_q [NumLanes];
  logic signed [MW-1:0] e_m_q [NumLanes];
  logic                 e_neg_q [NumLanes];
  logic                 e_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      e_mm[i]   = d_m_q[i][MW-1] ? (F + 1)'(-d_m_q[i]) : (F + 1)'(d_m_q[i]);
      e_prod[i] = EW'(d_adj_q) * EW'(e_mm[i]);
      e_rnd[i]  = e_prod[i] + (EW'(1) << (F - 1));
    end
  end

  // Stage F: num = t - q, build the first dividend
  logic signed [F+2:0]  f_t [NumLanes];
  logic signed [F+3:0]  f_q [NumLanes];
  logic signed [F+4:0]  f_num [NumLanes];
  logic [NMW-1:0]       f_nmag [NumLanes];
  logic [N1W-1:0]       f_n_q [NumLanes];
  logic [DDW-1:0]       f_d_q;
  logic signed [MW-1:0] f_m_q [NumLanes];
  logic                 f_nneg_q [NumLanes];
  logic                 f_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      f_t[i]    = e_neg_q[i] ? -$signed({1'b0, e_tm_q[i]}) : $signed({1'b0, e_tm_q[i]});
      f_q[i]    = e_m_q[i][MW-1] ? -$signed({1'b0, e_qm_q[i]}) : $signed({1'b0, e_qm_q[i]});
      f_num[i]  = (F + 5)'(f_t[i]) - (F + 5)'(f_q[i]);
      f_nmag[i] = f_num[i][F+4] ? NMW'(-f_num[i]) : NMW'(f_num[i]);
    end
  end

  // Advance stages A to F
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_adj_q <= d_rnd[F+1 +: ADW];
    d_d_q   <= DDW'(d_rnd[F+1 +: ADW]) + (DDW'(1) << F);
    e_d_q   <= d_d_q;
    f_d_q   <= e_d_q;
    for (int i = 0; i < NumLanes; i++) begin
      a_m_q[i]    <= a_m_d[i];
      a_p_q[i]    <= a_p_d[i];
      a_neg_q[i]  <= rate_in[i][31];
      b_tm_q[i]   <= b_tm_d[i];
      b_m_q[i]    <= a_m_q[i];
      b_neg_q[i]  <= a_neg_q[i];
      c_sq_q[i]   <= SQW'(b_tm_q[i]) * SQW'(b_tm_q[i]);
      c_tm_q[i]   <= b_tm_q[i];
      c_m_q[i]    <= b_m_q[i];
      c_neg_q[i]  <= b_neg_q[i];
      d_tm_q[i]   <= c_tm_q[i];
      d_m_q[i]    <= c_m_q[i];
      d_neg_q[i]  <= c_neg_q[i];
      e_qm_q[i]   <= e_rnd[i][F +: QMW];
      e_tm_q[i]   <= d_tm_q[i];
      e_m_q[i]    <= d_m_q[i];
      e_neg_q[i]  <= d_neg_q[i];
      f_n_q[i]    <= (N1W'(f_nmag[i]) << F) + N1W'(e_d_q >> 1);
      f_m_q[i]    <= e_m_q[i];
      f_nneg_q[i] <= f_num[i][F+4];
    end
  end

  // First divider: t' = num / (1 + adj), one lane per component
  logic           dv1_vld [NumLanes];
  logic [Q1W-1:0] dv1_q [NumLanes];
  logic [MW:0]    dv1_tag [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_div1
    uveu_div_pipe #(
      .NW(N1W),
      .DW(DDW),
      .QW(Q1W),
      .TW(MW + 1)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (f_vld_q),
      .dividend_i(f_n_q[l]),
      .divisor_i (f_d_q),
      .tag_i     ({f_nneg_q[l], f_m_q[l]}),
      .valid_o   (dv1_vld[l]),
      .quot_o    (dv1_q[l]),
      .tag_o     (dv1_tag[l])
    );
  end

  // Stage G: v = m + t'
  logic signed [F+3:0] g_v [NumLanes];
  logic signed [F+3:0] g_tp [NumLanes];
  logic [VMW-1:0]      g_vm_q [NumLanes];
  logic                g_vneg_q [NumLanes];
  logic                g_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      g_tp[i] = dv1_tag[i][MW] ? -$signed((F + 4)'(dv1_q[i])) : $signed((F + 4)'(dv1_q[i]));
      g_v[i]  = (F + 4)'($signed(dv1_tag[i][MW-1:0])) + g_tp[i];
    end
  end

  // Stage H: quarter squares; stage I: sum of squares
  logic [SW-1:0]  h_prod [NumLanes];
  logic [SW-3:0]  h_sq_q [NumLanes];
  logic [VMW-1:0] h_vm_q [NumLanes];
  logic           h_vneg_q [NumLanes];
  logic           h_vld_q;
  logic [SW-1:0]  i_s_q;
  logic [VMW-1:0] i_vm_q [NumLanes];
  logic           i_vneg_q [NumLanes];
  logic           i_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      h_prod[i] = SW'(g_vm_q[i]) * SW'(g_vm_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else begin
      g_vld_q <= dv1_vld[0];
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_s_q <= SW'(h_sq_q[0]) + SW'(h_sq_q[1]) + SW'(h_sq_q[2]);
    for (int i = 0; i < NumLanes; i++) begin
      g_vm_q[i]   <= g_v[i][F+3] ? VMW'(-g_v[i]) : VMW'(g_v[i]);
      g_vneg_q[i] <= g_v[i][F+3];
      h_sq_q[i]   <= h_prod[i][SW-1:2];
      h_vm_q[i]   <= g_vm_q[i];
      h_vneg_q[i] <= g_vneg_q[i];
      i_vm_q[i]   <= h_vm_q[i];
      i_vneg_q[i] <= h_vneg_q[i];
    end
  end

  // Square root of the quarter-scaled squared length
  localparam int VTW = NumLanes * (VMW + 1);
  logic           sq_vld;
  logic [RW-1:0]  sq_r;
  logic [VTW-1:0] sq_tag;

  uveu_sqrt_pipe #(
    .SW(SW),
    .TW(VTW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(i_vld_q),
    .rad_i  (i_s_q),
    .tag_i  ({i_vneg_q[2], i_vm_q[2], i_vneg_q[1], i_vm_q[1], i_vneg_q[0], i_vm_q[0]}),
    .valid_o(sq_vld),
    .root_o (sq_r),
    .tag_o  (sq_tag)
  );

  // Stage J: second dividend v * 2^(F-1) + r/2
  logic [N2W-1:0] j_n_q [NumLanes];
  logic [RW-1:0]  j_r_q;
  logic           j_rz_q;
  logic           j_vneg_q [NumLanes];
  logic           j_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_vld_q <= 1'b0;
    end else begin
      j_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    j_r_q  <= sq_r;
    j_rz_q <= (sq_r == '0);
    for (int i = 0; i < NumLanes; i++) begin
      j_n_q[i]    <= (N2W'(sq_tag[i*(VMW+1) +: VMW]) << (F - 1)) + N2W'(sq_r >> 1);
      j_vneg_q[i] <= sq_tag[i*(VMW+1) + VMW];
    end
  end

  // Second divider: scale each component by 1/|v|
  logic           dv2_vld [NumLanes];
  logic [Q2W-1:0] dv2_q [NumLanes];
  logic [1:0]     dv2_tag [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_div2
    uveu_div_pipe #(
      .NW(N2W),
      .DW(RW),
      .QW(Q2W),
      .TW(2)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (j_vld_q),
      .dividend_i(j_n_q[l]),
      .divisor_i (j_r_q),
      .tag_i     ({j_rz_q, j_vneg_q[l]}),
      .valid_o   (dv2_vld[l]),
      .quot_o    (dv2_q[l]),
      .tag_o     (dv2_tag[l])
    );
  end

  // Output stage: saturate, restore sign, handle a zero vector
  logic [Q2W-1:0] o_om [NumLanes];
  logic [31:0]    o_mag [NumLanes];
  logic [31:0]    o_d [NumLanes];
  logic [31:0]    o_q [NumLanes];
  logic           o_vld_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      o_om[i]  = (dv2_q[i] > (Q2W'(1) << F)) ? (Q2W'(1) << F) : dv2_q[i];
      o_mag[i] = 32'(o_om[i]);
      if (dv2_tag[i][1]) begin
        o_d[i] = (i == 0) ? 32'(SpinMax) : 32'd0;
      end else if (dv2_tag[i][0]) begin
        o_d[i] = 32'(-o_mag[i]);
      end else begin
        o_d[i] = o_mag[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= dv2_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    o_q <= o_d;
  end

  assign valid_o = o_vld_q;
  assign new_x_o = o_q[0];
  assign new_y_o = o_q[1];
  assign new_z_o = o_q[2];

  // Every accepted item comes out after the fixed pipeline latency
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency valid_o)
    else $error("result missing after pipeline latency");

  // Nothing comes out that was not taken in
  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, Latency))
    else $error("result without a matching item");

  // Results stay within the unit range
  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (new_x_o <= SpinMax) && (new_x_o >= -SpinMax) &&
                (new_y_o <= SpinMax) && (new_y_o >= -SpinMax) &&
                (new_z_o <= SpinMax) && (new_z_o >= -SpinMax))
    else $error("result component out of unit range");

endmodule

[hw/rtl/uveu_div_pipe.sv]
// Restoring divider, one quotient bit per register stage. The caller
// guarantees dividend < divisor * 2^QW. A side tag travels with each item.
module uveu_div_pipe #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] div_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [TW-1:0] tag_q [QW];
  logic          vld_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [W-1:0]  rem_in;
    logic [DW-1:0] div_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [W-1:0]  dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = W'(dividend_i);
      assign div_in = divisor_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // Trial subtract of the divisor aligned to this quotient bit
    assign dsh = W'(div_in) << J;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rem_in - dsh) : rem_in;
      div_q[k] <= div_in;
      quo_q[k] <= {quo_in[QW-2:0], ge};
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

[hw/rtl/uveu_sqrt_pipe.sv]
// Integer square root (floor), one result bit per register stage.
module uveu_sqrt_pipe #(
  parameter int SW = 64,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [SW-1:0]   rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [SW/2-1:0] root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int RW = SW / 2;

  logic [SW-1:0] rem_q [RW];
  logic [SW-1:0] res_q [RW];
  logic [TW-1:0] tag_q [RW];
  logic          vld_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = SW - 2 - 2 * k;
    logic [SW-1:0] rem_in;
    logic [SW-1:0] res_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [SW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // Try to take res + bit out of the remainder
    assign trial = {1'b0, res_in} + ((SW + 1)'(1) << B);
    assign ge    = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? SW'({1'b0, rem_in} - trial) : rem_in;
      res_q[k] <= ge ? ((res_in >> 1) + (SW'(1) << B)) : (res_in >> 1);
      tag_q[k] <= tag_in;
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = res_q[RW-1][RW-1:0];
  assign tag_o   = tag_q[RW-1];

endmodule

[test/unit_vector_euler_update_top_tb.sv]
`timescale 1ns / 1ps

module unit_vector_euler_update_top_tb;
  import uveu_pkg::*;

  localparam int FRAC = SpinFracBitsDef;
  localparam int LATENCY = 3 * FRAC + 17;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [2:0] StepAddr = 3'(CfgStepSize) << 2;
  localparam logic [2:0] UnusedAddr = 3'd4;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz, rx, ry, rz;
  } cell_t;

  typedef struct packed {
    logic signed [31:0] nx, ny, nz;
  } spin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] spin_x_i = '0, spin_y_i = '0, spin_z_i = '0;
  logic signed [31:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic valid_o;
  logic signed [31:0] new_x_o, new_y_o, new_z_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  unit_vector_euler_update_top dut (.*);

  always #10 clk_i = ~clk_i;

  cell_t cells_pending[$];
  spin_t spins_expected[$];
  logic [31:0] step_model = '0;
  int errors = 0;
  int cells_sent = 0;
  int spins_seen = 0;
  int cycles = 0;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_as(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (longint'(1) << b);
      if (trial * trial <= s) res = trial;
    end
    return res;
  endfunction

  // Advance one cell's spin by one Euler step and renormalize
  function automatic spin_t advance_spin(cell_t c, logic [31:0] h);
    longint one, sp, rt, num;
    longint m[3], t[3], v[3], o[3];
    longint unsigned tsat, p, tm, sumsq, adj, d, qm, tpm, vm, s, r, om;
    logic signed [31:0] spins[3], rates[3];
    spin_t res;
    one = longint'(1) << FRAC;
    tsat = longint'(1) << (FRAC + 1);
    spins = '{c.sx, c.sy, c.sz};
    rates = '{c.rx, c.ry, c.rz};
    sumsq = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      sp = spins[i];
      rt = rates[i];
      if (sp > one) sp = one;
      if (sp < -one) sp = -one;
      m[i] = sp;
      p = magnitude(rt) * longint'(h);
      if (p >= (longint'(1) << 57)) tm = tsat;
      else begin
        tm = (p + (longint'(1) << (55 - FRAC))) >> (56 - FRAC);
        if (tm > tsat) tm = tsat;
      end
      t[i] = signed_as(tm, rt < 0);
      sumsq += tm * tm;
    end
    adj = (sumsq + (longint'(1) << FRAC)) >> (FRAC + 1);
    d = (longint'(1) << FRAC) + adj;
    for (int i = 0; i < 3; i++) begin
      qm = (adj * magnitude(m[i]) + (longint'(1) << (FRAC - 1))) >> FRAC;
      num = t[i] - signed_as(qm, m[i] < 0);
      tpm = ((magnitude(num) << FRAC) + d / 2) / d;
      v[i] = m[i] + signed_as(tpm, num < 0);
      vm = magnitude(v[i]);
      s += (vm * vm) >> 2;
    end
    r = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      if (r == 0) o[i] = (i == 0) ? one : 0;
      else begin
        om = ((magnitude(v[i]) << (FRAC - 1)) + r / 2) / r;
        if (om > one) om = one;
        o[i] = signed_as(om, v[i] < 0);
      end
    end
    res.nx = o[0][31:0];
    res.ny = o[1][31:0];
    res.nz = o[2][31:0];
    return res;
  endfunction

  // Feed pending items; record the expected spin of each accepted item
  always @(posedge clk_i) begin
    bit idle;
    if (rst_ni) begin
      if (start && !busy) begin
        spins_expected.push_back(advance_spin(cells_pending.pop_front(), step_model));
        cells_sent++;
      end
      idle = (cells_sent < 400 || cells_sent > 650) && ($urandom_range(99) < 14);
      if (cells_pending.size() != 0 && !idle) begin
        start <= 1'b1;
        spin_x_i <= cells_pending[0].sx;
        spin_y_i <= cells_pending[0].sy;
        spin_z_i <= cells_pending[0].sz;
        rate_x_i <= cells_pending[0].rx;
        rate_y_i <= cells_pending[0].ry;
        rate_z_i <= cells_pending[0].rz;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    spin_t want;
    if (rst_ni && valid_o) begin
      spins_seen++;
      if (spins_expected.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, new_x_o, new_y_o,
                 new_z_o);
        errors++;
      end else begin
        want = spins_expected.pop_front();
        if (new_x_o !== want.nx) begin
          $display("%0t: new_x expected %0d actual %0d", $time, want.nx, new_x_o);
          errors++;
        end
        if (new_y_o !== want.ny) begin
          $display("%0t: new_y expected %0d actual %0d", $time, want.ny, new_y_o);
          errors++;
        end
        if (new_z_o !== want.nz) begin
          $display("%0t: new_z expected %0d actual %0d", $time, want.nz, new_z_o);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, spins_expected.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == StepAddr) step_model = data;
    // read the step size back
    @(posedge clk_i);
    psel <= 1'b1;
    paddr <= StepAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== step_model) begin
      $display("%0t: step_size readback expected %0h actual %0h", $time, step_model,
               prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every item has gone through and the pipeline is drained
  task automatic drain();
    wait (cells_pending.size() == 0 && !start && spins_expected.size() == 0);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_spin();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed(32'($urandom_range(32'h8000_0000))) - 32'sh4000_0000;
  endfunction

  function automatic logic signed [31:0] rand_rate();
    logic signed [31:0] r;
    r = $urandom;
    return r >>> $urandom_range(31);
  endfunction

  task automatic add_cell(logic signed [31:0] sx, sy, sz, rx, ry, rz);
    cell_t c;
    c = '{sx, sy, sz, rx, ry, rz};
    cells_pending.push_back(c);
  endtask

  task automatic add_random(int n);
    for (int k = 0; k < n; k++)
      add_cell(rand_spin(), rand_spin(), rand_spin(), rand_rate(), rand_rate(), rand_rate());
  endtask

  task automatic add_directed();
    logic signed [31:0] one, mx, mn;
    one = 32'sh4000_0000;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    add_cell(0, 0, 0, 0, 0, 0);
    add_cell(one, 0, 0, 0, 0, 0);
    add_cell(-one, 0, 0, mx, mx, mx);
    add_cell(0, one, 0, mn, mn, mn);
    add_cell(0, 0, -one, mx, mn, 1);
    add_cell(mx, mn, mx, 0, 0, 0);
    add_cell(mn, mx, mn, -1, 1, -1);
    add_cell(one, one, one, mx, 0, mn);
    add_cell(-one, -one, -one, 32'sh0100_0000, -32'sh0100_0000, 32'sh10);
    add_cell(one, 0, 0, -mx, 0, 0);
    add_cell(32'sh2d41_3ccd, 32'sh2d41_3ccd, 0, 32'sh0001_0000, -32'sh0001_0000, 0);
    add_cell(0, 0, one, 32'sh0040_0000, 32'sh0002_0000, mn);
  endtask

  initial begin
    logic [31:0] steps[6];
    steps = '{32'hffff_ffff, 32'h0000_0001, 32'h0400_0000, 32'h0000_4000, 0, 0};
    steps[4] = $urandom;
    steps[5] = $urandom_range(32'h00ff_ffff);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // step size zero after reset: zero sum vector and unit vectors pass through
    add_directed();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      cfg_write(StepAddr, steps[ph]);
      if (ph == 1) cfg_write(UnusedAddr, 32'hdead_beef);
      add_directed();
      add_random(ph == 4 ? 500 : 140);
      drain();
    end
    $display("Covered %0d cells over six step sizes plus reset default, %0d results.",
             cells_sent, spins_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
